[src/pfn_pkg.sv]
// ----------------------------------------------------------------------------
// pfn_pkg: shared types and constants of the polygon face normal unit
// Field widths, register indexes and the side data that travels along with
// the square-root and divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package pfn_pkg;

  localparam int VW         = 32;  // vertex coordinate, Q16.16
  localparam int EW         = 33;  // exact edge
  localparam int ES         = 31;  // edge after range reduction, signed
  localparam int PW         = 62;  // edge product
  localparam int CMW        = 62;  // cross product magnitude
  localparam int NW         = 30;  // normalised magnitude
  localparam int SQW        = 62;  // sum of squares
  localparam int RW         = 31;  // square root
  localparam int DW         = 32;  // divisor, twice the length
  localparam int NUMW       = 48;  // dividend and remainder
  localparam int QW         = 16;  // quotient
  localparam int OW         = 16;  // Q2.14 output
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int MIN_CORNERS = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CORNERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT    = 2'd1;

  localparam logic [OW-1:0] Q14_ONE = 16'd16384;

  typedef struct packed {
    logic [2:0][NW-1:0] cm;
    logic [2:0]         neg;
    logic               zero;
    logic               last_poly;
  } pfn_tag_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    logic       last_poly;
  } pfn_dtag_t;

endpackage

`default_nettype wire

[src/pfn_isqrt.sv]
// ----------------------------------------------------------------------------
// pfn_isqrt: pipelined integer square root
// One result bit per stage; the remainder x - root^2 is carried so that each
// stage needs only a shift, an add and a compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pfn_isqrt import pfn_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_v,
  input  wire logic [SQW-1:0]  in_x,
  input  wire pfn_tag_t        in_tag,
  output logic                 out_v,
  output logic [RW-1:0]        out_root,
  output pfn_tag_t             out_tag
);

  localparam int NST = RW;

  logic [SQW-1:0] rem_r  [NST];
  logic [RW-1:0]  root_r [NST];
  pfn_tag_t       tag_r  [NST];
  logic [NST-1:0] v_r;

  for (genvar g = 0; g < NST; g++) begin : gen_stage
    localparam int BI = RW - 1 - g;
    logic [SQW-1:0] rem_src, rem_nxt;
    logic [RW-1:0]  root_src, root_nxt;
    pfn_tag_t       tag_src;
    logic           v_src;
    logic [63:0]    term;

    if (g == 0) begin : gen_first
      assign rem_src  = in_x;
      assign root_src = '0;
      assign tag_src  = in_tag;
      assign v_src    = in_v;
    end else begin : gen_next
      assign rem_src  = rem_r[g-1];
      assign root_src = root_r[g-1];
      assign tag_src  = tag_r[g-1];
      assign v_src    = v_r[g-1];
    end

    // Setting bit BI raises root^2 by root*2^(BI+1) + 2^(2*BI).
    always_comb begin
      term     = ({33'd0, root_src} << (BI + 1)) + (64'd1 << (2 * BI));
      rem_nxt  = rem_src;
      root_nxt = root_src;
      if ({2'b00, rem_src} >= term) begin
        rem_nxt  = rem_src - term[SQW-1:0];
        root_nxt = root_src | (RW'(1) << BI);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        tag_r[g]  <= tag_src;
      end
    end
  end

  assign out_v    = v_r[NST-1];
  assign out_root = root_r[NST-1];
  assign out_tag  = tag_r[NST-1];

endmodule

`default_nettype wire

[src/pfn_div3.sv]
// ----------------------------------------------------------------------------
// pfn_div3: three-lane pipelined restoring divider
// The three dividends share one divisor; one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pfn_div3 import pfn_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_v,
  input  wire logic [2:0][NUMW-1:0] in_n,
  input  wire logic [DW-1:0]        in_d,
  input  wire pfn_dtag_t            in_tag,
  output logic                      out_v,
  output logic [2:0][QW-1:0]        out_q,
  output pfn_dtag_t                 out_tag
);

  localparam int NST = QW;

  logic [2:0][NUMW-1:0] r_r [NST];
  logic [2:0][QW-1:0]   q_r [NST];
  logic [DW-1:0]        d_r [NST];
  pfn_dtag_t            tag_r [NST];
  logic [NST-1:0]       v_r;

  for (genvar g = 0; g < NST; g++) begin : gen_stage
    localparam int BJ = QW - 1 - g;
    logic [2:0][NUMW-1:0] r_src, r_nxt;
    logic [2:0][QW-1:0]   q_src, q_nxt;
    logic [DW-1:0]        d_src;
    pfn_dtag_t            tag_src;
    logic                 v_src;
    logic [NUMW-1:0]      dsh;

    if (g == 0) begin : gen_first
      assign r_src   = in_n;
      assign q_src   = '0;
      assign d_src   = in_d;
      assign tag_src = in_tag;
      assign v_src   = in_v;
    end else begin : gen_next
      assign r_src   = r_r[g-1];
      assign q_src   = q_r[g-1];
      assign d_src   = d_r[g-1];
      assign tag_src = tag_r[g-1];
      assign v_src   = v_r[g-1];
    end

    always_comb begin
      dsh   = {{(NUMW-DW){1'b0}}, d_src} << BJ;
      r_nxt = r_src;
      q_nxt = q_src;
      for (int l = 0; l < 3; l++) begin
        if (r_src[l] >= dsh) begin
          r_nxt[l] = r_src[l] - dsh;
          q_nxt[l] = q_src[l] | (QW'(1) << BJ);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[g]   <= r_nxt;
        q_r[g]   <= q_nxt;
        d_r[g]   <= d_src;
        tag_r[g] <= tag_src;
      end
    end
  end

  assign out_v   = v_r[NST-1];
  assign out_q   = q_r[NST-1];
  assign out_tag = tag_r[NST-1];

endmodule

`default_nettype wire

[src/polygon_face_normal_unit.sv]
// ----------------------------------------------------------------------------
// polygon_face_normal_unit: unit face normal of a polygon, one copy per corner
// Edges, range reduction, cross product, normalisation, square root and
// division run in one stalling pipeline that feeds a repeating output register.
// ----------------------------------------------------------------------------
// A polygon item enters on any cycle in which in_ready is high, and the
// pipeline holds many polygons at once. Each polygon then produces k result
// items, k being corners_per_polygon clamped to 3..MAX_CORNERS, one per cycle
// from the output register while out_ready is high, so that output register
// sets the sustained rate. From acceptance to the first result an item passes
// eight arithmetic stages, 31 square-root stages, 16 divider stages and the
// output register. A zero cross product gives the normal (0,0,0);
// flat-terrain mode gives (0,16384,0) on every copy.
`default_nettype none

module polygon_face_normal_unit import pfn_pkg::*; #(
  parameter int MAX_CORNERS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [VW-1:0]  in_v0_x,
  input  wire logic signed [VW-1:0]  in_v0_y,
  input  wire logic signed [VW-1:0]  in_v0_z,
  input  wire logic signed [VW-1:0]  in_v1_x,
  input  wire logic signed [VW-1:0]  in_v1_y,
  input  wire logic signed [VW-1:0]  in_v1_z,
  input  wire logic signed [VW-1:0]  in_v2_x,
  input  wire logic signed [VW-1:0]  in_v2_y,
  input  wire logic signed [VW-1:0]  in_v2_z,
  input  wire logic                  in_final_polygon,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [OW-1:0]       out_normal_x,
  output logic signed [OW-1:0]       out_normal_y,
  output logic signed [OW-1:0]       out_normal_z,
  output logic                       out_last_corner,
  output logic                       out_mesh_end
);

  localparam int CW = $clog2(MAX_CORNERS + 1);
  localparam int KW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] corners_r;
  logic                  flat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corners_r <= CFG_DATA_W'(MIN_CORNERS);
      flat_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CORNERS: corners_r <= cfg_wdata;
        REG_FLAT:    flat_r    <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  logic [KW-1:0] k_ext, k_clamp;
  logic [CW-1:0] k_last;

  always_comb begin
    k_ext = KW'(corners_r);
    if (k_ext < KW'(MIN_CORNERS)) begin
      k_clamp = KW'(MIN_CORNERS);
    end else if (k_ext > KW'(MAX_CORNERS)) begin
      k_clamp = KW'(MAX_CORNERS);
    end else begin
      k_clamp = k_ext;
    end
    k_last = CW'(k_clamp - KW'(1));
  end

  // Global advance: everything moves unless the divider's last stage is full
  // and cannot hand its item to the output register.
  logic en, pop, div_v;
  logic hold_v_r, out_fire, is_last;

  assign out_fire = hold_v_r && out_ready;
  assign pop      = div_v && (!hold_v_r || (out_fire && is_last));
  assign en       = !div_v || pop;
  assign in_ready = en;

  // Stage 1: exact edges as sign and magnitude.
  logic [5:0][EW-1:0] s1_m_r;
  logic [5:0]         s1_n_r;
  logic               s1_v_r, s1_last_r;
  logic signed [EW-1:0] e_raw [6];

  always_comb begin
    e_raw[0] = EW'(in_v0_x) - EW'(in_v1_x);
    e_raw[1] = EW'(in_v0_y) - EW'(in_v1_y);
    e_raw[2] = EW'(in_v0_z) - EW'(in_v1_z);
    e_raw[3] = EW'(in_v1_x) - EW'(in_v2_x);
    e_raw[4] = EW'(in_v1_y) - EW'(in_v2_y);
    e_raw[5] = EW'(in_v1_z) - EW'(in_v2_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        s1_n_r[i] <= e_raw[i][EW-1];
        s1_m_r[i] <= e_raw[i][EW-1] ? EW'(-e_raw[i]) : EW'(e_raw[i]);
      end
      s1_last_r <= in_final_polygon;
    end
  end

  // Stage 2: shift every edge magnitude until all are below 2^30.
  logic signed [ES-1:0] s2_e_r [6];
  logic                 s2_v_r, s2_last_r;
  logic [EW-1:0]        m_or;
  logic [1:0]           e_sh;

  always_comb begin
    m_or = '0;
    for (int i = 0; i < 6; i++) m_or = m_or | s1_m_r[i];
    if (m_or[32])      e_sh = 2'd3;
    else if (m_or[31]) e_sh = 2'd2;
    else if (m_or[30]) e_sh = 2'd1;
    else               e_sh = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        s2_e_r[i] <= s1_n_r[i] ? -$signed(ES'(s1_m_r[i] >> e_sh))
                               : $signed(ES'(s1_m_r[i] >> e_sh));
      end
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: the six products of the cross product.
  logic signed [PW-1:0] s3_p_r [6];
  logic                 s3_v_r, s3_last_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p_r[0] <= PW'(s2_e_r[1]) * PW'(s2_e_r[5]);
      s3_p_r[1] <= PW'(s2_e_r[2]) * PW'(s2_e_r[4]);
      s3_p_r[2] <= PW'(s2_e_r[2]) * PW'(s2_e_r[3]);
      s3_p_r[3] <= PW'(s2_e_r[0]) * PW'(s2_e_r[5]);
      s3_p_r[4] <= PW'(s2_e_r[0]) * PW'(s2_e_r[4]);
      s3_p_r[5] <= PW'(s2_e_r[1]) * PW'(s2_e_r[3]);
      s3_last_r <= s2_last_r;
    end
  end

  // Stage 4: cross product components as sign and magnitude.
  logic [2:0][CMW-1:0]   s4_cm_r;
  logic [2:0]            s4_n_r;
  logic                  s4_v_r, s4_last_r;
  logic signed [PW:0]    c_raw [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_raw[i] = (PW+1)'(s3_p_r[2*i]) - (PW+1)'(s3_p_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_n_r[i]  <= c_raw[i][PW];
        s4_cm_r[i] <= c_raw[i][PW] ? CMW'(-c_raw[i]) : CMW'(c_raw[i]);
      end
      s4_last_r <= s3_last_r;
    end
  end

  // Stage 5: leading-one position of the largest magnitude, as a shift.
  logic [2:0][CMW-1:0] s5_cm_r;
  logic [2:0]          s5_n_r;
  logic                s5_v_r, s5_last_r, s5_zero_r, s5_right_r;
  logic [5:0]          s5_amt_r;
  logic [CMW-1:0]      c_or;
  logic [5:0]          lead;
  logic                sh_right;
  logic [5:0]          sh_amt;

  always_comb begin
    c_or = s4_cm_r[0] | s4_cm_r[1] | s4_cm_r[2];
    lead = '0;
    for (int b = 0; b < CMW; b++) begin
      if (c_or[b]) lead = 6'(b);
    end
    sh_right = 1'b0;
    sh_amt   = '0;
    if (lead >= 6'(NW)) begin
      sh_right = 1'b1;
      sh_amt   = lead - 6'(NW - 1);
    end else if (lead < 6'(NW - 1)) begin
      sh_amt   = 6'(NW - 1) - lead;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_cm_r    <= s4_cm_r;
      s5_n_r     <= s4_n_r;
      s5_zero_r  <= (c_or == '0);
      s5_right_r <= sh_right;
      s5_amt_r   <= sh_amt;
      s5_last_r  <= s4_last_r;
    end
  end

  // Stage 6: bring the largest magnitude into [2^29, 2^30).
  pfn_tag_t s6_tag_r;
  logic     s6_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_tag_r.cm[i] <= s5_right_r ? NW'(s5_cm_r[i] >> s5_amt_r)
                                     : NW'(s5_cm_r[i] << s5_amt_r);
      end
      s6_tag_r.neg       <= s5_n_r;
      s6_tag_r.zero      <= s5_zero_r;
      s6_tag_r.last_poly <= s5_last_r;
    end
  end

  // Stage 7: squares.
  logic [2:0][2*NW-1:0] s7_sq_r;
  pfn_tag_t             s7_tag_r;
  logic                 s7_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_sq_r[i] <= (2*NW)'(s6_tag_r.cm[i]) * (2*NW)'(s6_tag_r.cm[i]);
      end
      s7_tag_r <= s6_tag_r;
    end
  end

  // Stage 8: sum of squares.
  logic [SQW-1:0] s8_sum_r;
  pfn_tag_t       s8_tag_r;
  logic           s8_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_sum_r <= SQW'(s7_sq_r[0]) + SQW'(s7_sq_r[1]) + SQW'(s7_sq_r[2]);
      s8_tag_r <= s7_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  // Square root of the sum gives the length.
  logic          sq_v;
  logic [RW-1:0] len;
  pfn_tag_t      sq_tag;

  pfn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s8_v_r),
    .in_x     (s8_sum_r),
    .in_tag   (s8_tag_r),
    .out_v    (sq_v),
    .out_root (len),
    .out_tag  (sq_tag)
  );

  // Rounded quotient (cm * 2^15 + len) / (2 * len).
  logic [2:0][NUMW-1:0] dv_n;
  logic [DW-1:0]        dv_d;
  pfn_dtag_t            dv_tag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_n[i] = {{(NUMW-NW-15){1'b0}}, sq_tag.cm[i], 15'd0} + NUMW'(len);
    end
    dv_d             = sq_tag.zero ? DW'(1) : {len, 1'b0};
    dv_tag.neg       = sq_tag.neg;
    dv_tag.zero      = sq_tag.zero;
    dv_tag.last_poly = sq_tag.last_poly;
  end

  logic [2:0][QW-1:0] dv_q;
  pfn_dtag_t          dq_tag;

  pfn_div3 u_div3 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (sq_v),
    .in_n    (dv_n),
    .in_d    (dv_d),
    .in_tag  (dv_tag),
    .out_v   (div_v),
    .out_q   (dv_q),
    .out_tag (dq_tag)
  );

  // Saturate, apply the sign and the special cases.
  logic [2:0][OW-1:0] nrm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = (dv_q[i] > Q14_ONE) ? Q14_ONE : OW'(dv_q[i]);
      if (dq_tag.zero) nrm[i] = '0;
      if (dq_tag.neg[i]) nrm[i] = OW'(-nrm[i]);
    end
    if (flat_r) begin
      nrm[0] = '0;
      nrm[1] = Q14_ONE;
      nrm[2] = '0;
    end
  end

  // Output register, repeated once per corner.
  logic [2:0][OW-1:0] hold_n_r;
  logic               hold_last_r;
  logic [CW-1:0]      copy_cnt_r, copy_cnt_nxt;
  logic               hold_v_nxt;

  assign is_last = (copy_cnt_r == k_last);

  always_comb begin
    hold_v_nxt   = hold_v_r;
    copy_cnt_nxt = copy_cnt_r;
    if (out_fire) begin
      copy_cnt_nxt = is_last ? '0 : copy_cnt_r + CW'(1);
      if (is_last) hold_v_nxt = 1'b0;
    end
    if (pop) hold_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r   <= 1'b0;
      copy_cnt_r <= '0;
    end else begin
      hold_v_r   <= hold_v_nxt;
      copy_cnt_r <= copy_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold_n_r    <= nrm;
      hold_last_r <= dq_tag.last_poly;
    end
  end

  assign out_valid       = hold_v_r;
  assign out_normal_x    = hold_n_r[0];
  assign out_normal_y    = hold_n_r[1];
  assign out_normal_z    = hold_n_r[2];
  assign out_last_corner = is_last;
  assign out_mesh_end    = is_last && hold_last_r;

  a_mesh_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mesh_end |-> out_last_corner)
    else $error("mesh end flagged on a copy that is not the last corner");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_normal_x) <= 16384 && $signed(out_normal_x) >= -16384 &&
                   $signed(out_normal_y) <= 16384 && $signed(out_normal_y) >= -16384 &&
                   $signed(out_normal_z) <= 16384 && $signed(out_normal_z) >= -16384))
    else $error("normal component outside the Q2.14 unit range");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(copy_cnt_r) && out_valid)
    else $error("corner count moved while the result item was stalled");

  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    div_v && !en |=> div_v && $stable(dv_q))
    else $error("divider output lost while the pipeline was stalled");

endmodule

`default_nettype wire
